// ===== rtl/cst_pkg.sv =====
package cst_pkg;

  // Code units with a meaning of their own
  localparam logic [15:0] ChQuote = 16'h0022;
  localparam logic [15:0] ChComma = 16'h002C;
  localparam logic [15:0] ChCr    = 16'h000D;
  localparam logic [15:0] ChLf    = 16'h000A;
  localparam logic [15:0] ChBom   = 16'hFEFF;

  // Status codes
  localparam logic [1:0] StatusOk           = 2'd0;
  localparam logic [1:0] StatusBadQuote     = 2'd1;
  localparam logic [1:0] StatusUnterminated = 2'd2;

  // Quote tracking modes
  localparam logic [1:0] QmOutside   = 2'd0;
  localparam logic [1:0] QmInside    = 2'd1;
  localparam logic [1:0] QmQuoteSeen = 2'd2;
  localparam logic [1:0] QmUnused    = 2'd3;

  typedef struct packed {
    logic [15:0] char_code;
    logic        end_of_data;
  } in_item_t;

  typedef struct packed {
    logic        char_valid;
    logic [15:0] out_char;
    logic        field_end;
    logic        record_end;
    logic [1:0]  status;
    logic        stream_done;
  } out_item_t;

endpackage

// ===== rtl/csv_stream_tokenizer_top.sv =====
// CSV stream tokenizer (RFC 4180 style) over UTF-16 code units.
//
// Input channel: in_valid_i / in_stall_o carry one in_item_t per transaction,
// either one code unit or an end-of-data mark. Output channel: out_valid_o /
// out_stall_i carry exactly one out_item_t for each input transaction: a
// field character, field/record end marks, the sticky status and, for the
// end-of-data item, stream_done.
//
// The tokenizer state and the result register load at the edge that
// accepts the input. Throughput is one item per cycle while the receiver
// does not stall; the single output register is refilled in the same
// cycle it is emptied.
//
// Reset (rst_ni low, asynchronous) clears the output valid and puts the
// tokenizer at text start with no error. The end-of-data item returns the
// state to the same point, so a new text may follow at once.
//
// When the receiver stalls with a result waiting, in_stall_o rises and the
// held result stays unchanged until it is taken.
module csv_stream_tokenizer_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cst_pkg::in_item_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cst_pkg::out_item_t out_data_o
);

  // Tokenizer state
  logic [1:0] quote_mode_q, quote_mode_d;
  logic       field_has_data_q, field_has_data_d;
  logic       row_has_fields_q, row_has_fields_d;
  logic       after_cr_q, after_cr_d;
  logic       at_start_q, at_start_d;
  logic [1:0] error_q, error_d;

  // Output register
  logic               out_valid_q;
  cst_pkg::out_item_t out_data_q;
  cst_pkg::out_item_t result;

  logic        in_accept;
  logic        unquoted;
  logic [15:0] c;

  // Stall only while a result waits and the receiver holds it off
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign c          = in_data_i.char_code;

  always_comb begin
    result           = '0;
    quote_mode_d     = quote_mode_q;
    field_has_data_d = field_has_data_q;
    row_has_fields_d = row_has_fields_q;
    after_cr_d       = after_cr_q;
    at_start_d       = at_start_q;
    error_d          = error_q;
    unquoted         = 1'b0;

    if (in_data_i.end_of_data) begin
      // Flush and return to text start
      if (error_q == cst_pkg::StatusOk &&
          (quote_mode_q inside {cst_pkg::QmInside, cst_pkg::QmUnused})) begin
        error_d = cst_pkg::StatusUnterminated;
      end
      if (error_d == cst_pkg::StatusOk && (field_has_data_q || row_has_fields_q)) begin
        result.field_end  = 1'b1;
        result.record_end = 1'b1;
      end
      result.status      = error_d;
      result.stream_done = 1'b1;
      quote_mode_d     = cst_pkg::QmOutside;
      field_has_data_d = 1'b0;
      row_has_fields_d = 1'b0;
      after_cr_d       = 1'b0;
      at_start_d       = 1'b1;
      error_d          = cst_pkg::StatusOk;
    end else begin
      if (error_q == cst_pkg::StatusOk) begin
        after_cr_d = 1'b0;
        at_start_d = 1'b0;
        if (at_start_q && c == cst_pkg::ChBom) begin
          // leading byte-order mark: dropped
        end else if (quote_mode_q == cst_pkg::QmQuoteSeen) begin
          if (c == cst_pkg::ChQuote) begin
            // doubled quote: one literal quote
            result.char_valid = 1'b1;
            result.out_char   = cst_pkg::ChQuote;
            quote_mode_d      = cst_pkg::QmInside;
          end else begin
            // previous quote closed the field
            quote_mode_d = cst_pkg::QmOutside;
            unquoted     = 1'b1;
          end
        end else if (quote_mode_q != cst_pkg::QmOutside) begin
          if (c == cst_pkg::ChQuote) begin
            quote_mode_d = cst_pkg::QmQuoteSeen;
          end else begin
            result.char_valid = 1'b1;
            result.out_char   = c;
          end
        end else if (after_cr_q && c == cst_pkg::ChLf) begin
          // LF of a CRLF pair: dropped
        end else begin
          unquoted = 1'b1;
        end

        if (unquoted) begin
          case (c)
            cst_pkg::ChQuote: begin
              if (!field_has_data_q) begin
                quote_mode_d     = cst_pkg::QmInside;
                field_has_data_d = 1'b1;
              end else begin
                error_d = cst_pkg::StatusBadQuote;
              end
            end
            cst_pkg::ChComma: begin
              result.field_end = 1'b1;
              field_has_data_d = 1'b0;
              row_has_fields_d = 1'b1;
            end
            cst_pkg::ChCr, cst_pkg::ChLf: begin
              result.field_end  = 1'b1;
              result.record_end = 1'b1;
              field_has_data_d  = 1'b0;
              row_has_fields_d  = 1'b0;
              after_cr_d        = (c == cst_pkg::ChCr);
            end
            default: begin
              result.char_valid = 1'b1;
              result.out_char   = c;
              field_has_data_d  = 1'b1;
            end
          endcase
        end
      end
      result.status = error_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_mode_q     <= cst_pkg::QmOutside;
      field_has_data_q <= 1'b0;
      row_has_fields_q <= 1'b0;
      after_cr_q       <= 1'b0;
      at_start_q       <= 1'b1;
      error_q          <= cst_pkg::StatusOk;
      out_valid_q      <= 1'b0;
    end else begin
      if (in_accept) begin
        quote_mode_q     <= quote_mode_d;
        field_has_data_q <= field_has_data_d;
        row_has_fields_q <= row_has_fields_d;
        after_cr_q       <= after_cr_d;
        at_start_q       <= at_start_d;
        error_q          <= error_d;
        out_valid_q      <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload register: loads with every accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A record end always comes with a field end
  a_record_has_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.record_end || out_data_o.field_end))
    else $error("record_end without field_end");

  // End of data returns the tokenizer to text start with no error
  a_eod_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.end_of_data) |=>
      (at_start_q && error_q == cst_pkg::StatusOk && quote_mode_q == cst_pkg::QmOutside))
    else $error("state not reset after end of data");

  // A character and a field end never share one result
  a_char_xor_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.char_valid && out_data_o.field_end))
    else $error("character and field end together");

  // Once latched, an error stays until end of data
  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !in_data_i.end_of_data && error_q != cst_pkg::StatusOk) |=>
      (error_q == $past(error_q)))
    else $error("latched error changed");

endmodule

// ===== test/tb_csv_stream_tokenizer_top.sv =====
`timescale 1ns / 1ps

// Streaming CSV tokenizer testbench.
// A short table of hand-picked code units runs first: BOM handling, extreme
// code values, quoting, CRLF and both error kinds. Rows whose result is
// obvious carry it inline. All other rows, and the random texts after them,
// are checked against a cycle-free model of the tokenizer kept below.
module tb_csv_stream_tokenizer_top;
  import cst_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  csv_stream_tokenizer_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Tokenizer model state
  // ---------------------------------------------------------------------------
  logic [1:0] tk_mode;        // QmOutside / QmInside / QmQuoteSeen
  logic       tk_field_open;  // current field has begun
  logic       tk_row_open;    // record already holds a finished field
  logic       tk_after_cr;    // previous unit ended a record with CR
  logic       tk_at_start;    // nothing taken since reset / end of data
  logic [1:0] tk_status;      // latched error

  out_item_t tokens_due[$];   // results still owed by the DUT, oldest first
  out_item_t want_tok;

  typedef struct {
    in_item_t  stim;
    bit        typed;         // 1: check against 'want' instead of the model
    out_item_t want;
  } dir_row_t;
  dir_row_t dir_rows[$];

  int  n_sent;
  int  n_checked;
  int  n_errors;
  int  n_streams[4];          // finished texts, by final status
  bit  calm;                  // no idling on either side while set

  function automatic void reset_tokenizer();
    tk_mode       = QmOutside;
    tk_field_open = 1'b0;
    tk_row_open   = 1'b0;
    tk_after_cr   = 1'b0;
    tk_at_start   = 1'b1;
    tk_status     = StatusOk;
  endfunction

  // Unit handled outside quotes: open a quoted field, end a field or record,
  // or append the character.
  function automatic void plain_unit(logic [15:0] c, inout out_item_t r);
    if (c == ChQuote) begin
      if (!tk_field_open) begin
        tk_mode       = QmInside;
        tk_field_open = 1'b1;
      end else begin
        tk_status = StatusBadQuote;
      end
    end else if (c == ChComma) begin
      r.field_end   = 1'b1;
      tk_field_open = 1'b0;
      tk_row_open   = 1'b1;
    end else if (c == ChCr || c == ChLf) begin
      r.field_end   = 1'b1;
      r.record_end  = 1'b1;
      tk_field_open = 1'b0;
      tk_row_open   = 1'b0;
      tk_after_cr   = (c == ChCr);
    end else begin
      r.char_valid  = 1'b1;
      r.out_char    = c;
      tk_field_open = 1'b1;
    end
  endfunction

  function automatic out_item_t tokenize_unit(in_item_t it);
    out_item_t   r;
    logic        was_cr;
    logic        was_start;
    logic [15:0] c;
    r = '0;
    c = it.char_code;
    if (it.end_of_data) begin
      // open quote at end of text is an error; a pending quote just closes
      if (tk_status == StatusOk && (tk_mode == QmInside || tk_mode == QmUnused))
        tk_status = StatusUnterminated;
      if (tk_status == StatusOk && (tk_field_open || tk_row_open)) begin
        r.field_end  = 1'b1;
        r.record_end = 1'b1;
      end
      r.status      = tk_status;
      r.stream_done = 1'b1;
      reset_tokenizer();
      return r;
    end
    if (tk_status == StatusOk) begin
      was_cr      = tk_after_cr;
      was_start   = tk_at_start;
      tk_after_cr = 1'b0;
      tk_at_start = 1'b0;
      if (was_start && c == ChBom) begin
        // leading BOM dropped
      end else if (tk_mode == QmQuoteSeen) begin
        if (c == ChQuote) begin
          r.char_valid = 1'b1;
          r.out_char   = ChQuote;
          tk_mode      = QmInside;
        end else begin
          tk_mode = QmOutside;
          plain_unit(c, r);
        end
      end else if (tk_mode != QmOutside) begin
        if (c == ChQuote) begin
          tk_mode = QmQuoteSeen;
        end else begin
          r.char_valid = 1'b1;
          r.out_char   = c;
        end
      end else if (was_cr && c == ChLf) begin
        // LF of a CRLF pair
      end else begin
        plain_unit(c, r);
      end
    end
    r.status = tk_status;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table helpers
  // ---------------------------------------------------------------------------
  function automatic out_item_t res(int cv, logic [15:0] ch, int fe, int re,
                                    logic [1:0] st, int dn);
    return {1'(cv), ch, 1'(fe), 1'(re), st, 1'(dn)};
  endfunction

  function automatic void add_row(logic [15:0] code, logic eod, bit typed,
                                  out_item_t want);
    dir_row_t row;
    row.stim.char_code   = code;
    row.stim.end_of_data = eod;
    row.typed            = typed;
    row.want             = want;
    dir_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one transaction per call, with an optional idle burst first.
  // Valid stays high between back-to-back transactions.
  // ---------------------------------------------------------------------------
  task automatic send_unit(logic [15:0] code, logic eod, bit typed, out_item_t want);
    in_item_t  item;
    out_item_t model_tok;
    item.char_code   = code;
    item.end_of_data = eod;
    if (!calm && $urandom_range(0, 6) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 13)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    model_tok = tokenize_unit(item);
    tokens_due.push_back(typed ? want : model_tok);
    n_sent++;
    if (eod) n_streams[model_tok.status]++;
  endtask

  task automatic put(logic [15:0] code);
    send_unit(code, 1'b0, 1'b0, '0);
  endtask

  // end of data; the code unit riding along must be ignored
  task automatic put_eod();
    send_unit(16'($urandom_range(0, 65535)), 1'b1, 1'b0, '0);
  endtask

  // Sender holds off until every owed result has been taken.
  task automatic drain_tokens();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    for (int w = 0; w < 4000 && tokens_due.size() != 0; w++) @(posedge clk_i);
  endtask

  // Field data for an unquoted field: never a separator or a quote.
  function automatic logic [15:0] plain_code();
    logic [15:0] c;
    do begin
      case ($urandom_range(0, 5))
        0:       c = 16'($urandom_range(0, 65535));
        1:       c = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
        2:       c = ChBom;
        default: c = 16'($urandom_range(16'h20, 16'h7E));
      endcase
    end while (c == ChQuote || c == ChComma || c == ChCr || c == ChLf);
    return c;
  endfunction

  // Inside quotes separators are plain data.
  function automatic logic [15:0] quoted_code();
    case ($urandom_range(0, 5))
      0:       return ChComma;
      1:       return ChCr;
      2:       return ChLf;
      default: return plain_code();
    endcase
  endfunction

  // Mostly well-formed text with random content; a few stray quotes,
  // trailing data after a closing quote and unterminated quotes mixed in.
  task automatic send_text();
    int n_rec;
    int n_fld;
    int len;
    int kind;
    if ($urandom_range(0, 3) == 0) put(ChBom);
    n_rec = $urandom_range(1, 4);
    for (int r = 0; r < n_rec; r++) begin
      n_fld = $urandom_range(1, 5);
      for (int f = 0; f < n_fld; f++) begin
        if (f != 0) put(ChComma);
        kind = $urandom_range(0, 9);
        len  = $urandom_range(0, 6);
        if (kind < 5) begin
          for (int i = 0; i < len; i++) put(plain_code());
          if (kind == 0 && $urandom_range(0, 3) == 0) put(ChQuote);
        end else if (kind < 9) begin
          put(ChQuote);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 4) == 0) begin
              put(ChQuote);
              put(ChQuote);
            end else begin
              put(quoted_code());
            end
          end
          put(ChQuote);
          if ($urandom_range(0, 7) == 0) put(plain_code());
        end
        // kind 9: empty field
      end
      if (r != n_rec - 1 || $urandom_range(0, 1)) begin
        case ($urandom_range(0, 2))
          0: put(ChCr);
          1: put(ChLf);
          default: begin
            put(ChCr);
            put(ChLf);
          end
        endcase
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      put(ChQuote);
      put(quoted_code());
    end
    put_eod();
  endtask

  // Raw noise: special units and arbitrary code values in any order.
  task automatic send_noise();
    repeat ($urandom_range(1, 20)) begin
      case ($urandom_range(0, 5))
        0:       put(ChQuote);
        1:       put(ChComma);
        2:       put(ChCr);
        3:       put(ChLf);
        4:       put(ChBom);
        default: put(16'($urandom_range(0, 65535)));
      endcase
    end
    put_eod();
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall bursts, none while calm.
  // ---------------------------------------------------------------------------
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(string what, out_item_t want, out_item_t got);
    n_errors++;
    if (n_errors <= 10)
      $display("%0t %s: expected cv=%0d ch=%h fe=%0d re=%0d st=%0d done=%0d,",
               $time, what, want.char_valid, want.out_char, want.field_end,
               want.record_end, want.status, want.stream_done,
               " got cv=%0d ch=%h fe=%0d re=%0d st=%0d done=%0d",
               got.char_valid, got.out_char, got.field_end, got.record_end,
               got.status, got.stream_done);
  endtask

  // Every accepted result is matched against the oldest owed one.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_checked++;
      if (tokens_due.size() == 0) begin
        report_mismatch("result with none owed", '0, out_data_o);
      end else begin
        want_tok = tokens_due.pop_front();
        if (out_data_o.char_valid  !== want_tok.char_valid  ||
            out_data_o.out_char    !== want_tok.out_char    ||
            out_data_o.field_end   !== want_tok.field_end   ||
            out_data_o.record_end  !== want_tok.record_end  ||
            out_data_o.status      !== want_tok.status      ||
            out_data_o.stream_done !== want_tok.stream_done)
          report_mismatch("result mismatch", want_tok, out_data_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int n_dir;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    calm       = 1'b0;
    reset_tokenizer();

    // text 1: BOM, extremes, quoting rules, CR / CRLF / LF, close at end
    add_row(ChBom,    1'b0, 1'b1, res(0, 16'h0000, 0, 0, StatusOk, 0)); // dropped
    add_row(16'h0000, 1'b0, 1'b1, res(1, 16'h0000, 0, 0, StatusOk, 0));
    add_row(16'hFFFF, 1'b0, 1'b1, res(1, 16'hFFFF, 0, 0, StatusOk, 0));
    add_row(ChComma,  1'b0, 1'b1, res(0, 16'h0000, 1, 0, StatusOk, 0));
    add_row(ChQuote,  1'b0, 1'b0, '0);    // opens quoted field
    add_row(ChQuote,  1'b0, 1'b0, '0);    // quote seen
    add_row(ChQuote,  1'b0, 1'b0, '0);    // doubled: one quote out
    add_row(ChComma,  1'b0, 1'b0, '0);    // comma is data inside quotes
    add_row(ChQuote,  1'b0, 1'b0, '0);    // closing quote
    add_row(16'h0062, 1'b0, 1'b0, '0);    // text after closing quote appended
    add_row(ChCr,     1'b0, 1'b1, res(0, 16'h0000, 1, 1, StatusOk, 0));
    add_row(ChLf,     1'b0, 1'b0, '0);    // LF of CRLF dropped
    add_row(ChLf,     1'b0, 1'b1, res(0, 16'h0000, 1, 1, StatusOk, 0));
    add_row(ChQuote,  1'b0, 1'b0, '0);
    add_row(ChQuote,  1'b0, 1'b0, '0);    // pending quote closes at end
    add_row(16'h1234, 1'b1, 1'b1, res(0, 16'h0000, 1, 1, StatusOk, 1));
    // text 2: quote after a closed quoted field already holding data
    add_row(ChQuote,  1'b0, 1'b0, '0);
    add_row(ChQuote,  1'b0, 1'b0, '0);
    add_row(16'h007A, 1'b0, 1'b0, '0);
    add_row(ChQuote,  1'b0, 1'b1, res(0, 16'h0000, 0, 0, StatusBadQuote, 0));
    add_row(16'h0000, 1'b1, 1'b1, res(0, 16'h0000, 0, 0, StatusBadQuote, 1));
    // text 3: quote in an unquoted field, then units ignored
    add_row(16'h0061, 1'b0, 1'b0, '0);
    add_row(ChQuote,  1'b0, 1'b1, res(0, 16'h0000, 0, 0, StatusBadQuote, 0));
    add_row(16'h0071, 1'b0, 1'b1, res(0, 16'h0000, 0, 0, StatusBadQuote, 0));
    add_row(16'hFFFF, 1'b1, 1'b1, res(0, 16'h0000, 0, 0, StatusBadQuote, 1));
    // text 4: unterminated quote; then an empty text
    add_row(ChQuote,  1'b0, 1'b0, '0);
    add_row(16'h0000, 1'b1, 1'b1, res(0, 16'h0000, 0, 0, StatusUnterminated, 1));
    add_row(16'h0000, 1'b1, 1'b1, res(0, 16'h0000, 0, 0, StatusOk, 1));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i])
      send_unit(dir_rows[i].stim.char_code, dir_rows[i].stim.end_of_data,
                dir_rows[i].typed, dir_rows[i].want);
    drain_tokens();

    // Random texts. Some texts run with no idling; the tail runs calm.
    n_dir = n_sent;
    while (n_sent < n_dir + 1400) begin
      calm = (n_sent > n_dir + 1250) || ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 7) == 0) send_noise();
      else                           send_text();
      if ($urandom_range(0, 9) == 0) drain_tokens();
    end

    drain_tokens();
    repeat (4) @(posedge clk_i);
    if (tokens_due.size() != 0) begin
      $display("%0d results never arrived", tokens_due.size());
      n_errors += tokens_due.size();
    end

    $display("Sent %0d transactions in %0d texts, checked %0d results",
             n_sent, n_streams[0] + n_streams[1] + n_streams[2], n_checked);
    $display("Texts ended clean / bad quote / unterminated: %0d / %0d / %0d",
             n_streams[StatusOk], n_streams[StatusBadQuote],
             n_streams[StatusUnterminated]);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== csv_stream_tokenizer_top.f =====
rtl/cst_pkg.sv
rtl/csv_stream_tokenizer_top.sv
test/tb_csv_stream_tokenizer_top.sv
